// ===== hdl/mom_pkg.sv =====
`default_nettype none

package mom_pkg;

    // Upper nibble of a status byte
    localparam logic [3:0] ST_NOTE_OFF    = 4'h8;
    localparam logic [3:0] ST_NOTE_ON     = 4'h9;
    localparam logic [3:0] ST_POLY_PRESS  = 4'hA;
    localparam logic [3:0] ST_CONTROL     = 4'hB;
    localparam logic [3:0] ST_PROGRAM     = 4'hC;
    localparam logic [3:0] ST_CHAN_PRESS  = 4'hD;
    localparam logic [3:0] ST_PITCH_BEND  = 4'hE;
    localparam logic [3:0] ST_SYSTEM      = 4'hF;

    // System bytes
    localparam logic [7:0] SYS_EX_START   = 8'hF0;
    localparam logic [7:0] MTC_QUARTER    = 8'hF1;
    localparam logic [7:0] SONG_POSITION  = 8'hF2;
    localparam logic [7:0] SONG_SELECT    = 8'hF3;
    localparam logic [7:0] SYS_EX_END     = 8'hF7;
    localparam logic [7:0] TIMING_CLOCK   = 8'hF8;
    localparam logic [7:0] ACTIVE_SENSING = 8'hFE;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       pop_valid;
        logic [1:0] pop_source;
        logic       activity;
    } result_t;

    typedef struct packed {
        logic       in_sysex;
        logic [1:0] data_left;
    } track_t;

    // Message bookkeeping after a byte has gone out
    function automatic track_t track_sent(input track_t st, input logic [7:0] b);
        track_t r;
        r = st;
        case (b[7:4])
            ST_NOTE_OFF, ST_NOTE_ON, ST_POLY_PRESS, ST_CONTROL, ST_PITCH_BEND: begin
                r.data_left = 2'd2;
            end
            ST_PROGRAM, ST_CHAN_PRESS: begin
                r.data_left = 2'd1;
            end
            ST_SYSTEM: begin
                case (b)
                    SYS_EX_START: begin
                        r.in_sysex  = 1'b1;
                        r.data_left = 2'd0;
                    end
                    SYS_EX_END: begin
                        r.in_sysex = 1'b0;
                    end
                    TIMING_CLOCK: begin
                        r = st;
                    end
                    MTC_QUARTER, SONG_SELECT: begin
                        r.data_left = 2'd1;
                    end
                    SONG_POSITION: begin
                        r.data_left = 2'd2;
                    end
                    default: begin
                        r.data_left = 2'd0;
                    end
                endcase
            end
            default: begin
                if (r.data_left != 2'd0) begin
                    r.data_left = r.data_left - 2'd1;
                end
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/mom_out_skid.sv =====
`default_nettype none

module mom_out_skid (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_load,
    input  wire mom_pkg::result_t in_data,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output mom_pkg::result_t      out_data
);
    import mom_pkg::*;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_data_reg, main_data_next;
    result_t skid_data_reg, skid_data_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_ready || !main_valid_reg) begin
            if (skid_valid_reg) begin
                // drain the skid stage first
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = in_load;
                main_data_next  = in_data;
            end
        end else if (in_load) begin
            // hold the new item beside the stalled one
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

`default_nettype wire

// ===== hdl/midi_output_merger.sv =====
`default_nettype none

// MIDI output merger: each item is one poll of the source queue heads and the
// transmitter's ready flag, and gives exactly one result (byte sent, queue
// popped, activity). One item is taken every cycle while s_ready is high; its
// result is registered onto the m_ channel. The per-item work is a single
// combinational pass over the merger state, and a two-entry output buffer
// keeps s_ready high while one result waits on m_ready. The block stays on a
// source until its message is complete, expands running status by inserting
// the source's last status byte before a bare data byte, and moves round-robin
// over NUM_SOURCES sources; sources beyond the four input lanes read as empty.
module midi_output_merger #(
    parameter int NUM_SOURCES = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [3:0] s_head_valid_mask,
    input  wire logic [7:0] s_head_byte_0,
    input  wire logic [7:0] s_head_byte_1,
    input  wire logic [7:0] s_head_byte_2,
    input  wire logic [7:0] s_head_byte_3,
    input  wire logic       s_tx_ready,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_tx_valid,
    output logic [7:0]      m_tx_byte,
    output logic            m_pop_valid,
    output logic [1:0]      m_pop_source,
    output logic            m_activity
);
    import mom_pkg::*;

    localparam int SRC_W = (NUM_SOURCES > 2) ? $clog2(NUM_SOURCES) : 1;

    logic [SRC_W-1:0] active_source_reg, active_source_next;
    logic [7:0]       last_status_reg [NUM_SOURCES];
    logic [7:0]       last_status_next [NUM_SOURCES];
    track_t           track_reg, track_next;
    logic [7:0]       held_data_reg, held_data_next;
    logic             held_valid_reg, held_valid_next;
    logic [7:0]       current_byte_reg, current_byte_next;
    logic             waiting_reg, waiting_next;

    logic       accept;
    logic [7:0] lane_byte [4];
    logic       have_head;
    logic [7:0] head;
    logic       msg_idle;
    logic       try_send;
    logic [7:0] send_byte;
    result_t    res;
    result_t    out_data;

    assign accept = s_valid && s_ready;

    assign lane_byte[0] = s_head_byte_0;
    assign lane_byte[1] = s_head_byte_1;
    assign lane_byte[2] = s_head_byte_2;
    assign lane_byte[3] = s_head_byte_3;

    always_comb begin
        have_head = 1'b0;
        head      = 8'h00;
        if (32'(active_source_reg) < 32'd4) begin
            have_head = s_head_valid_mask[2'(active_source_reg)];
            head      = lane_byte[2'(active_source_reg)];
        end
    end

    assign msg_idle = !track_reg.in_sysex && (track_reg.data_left == 2'd0);

    always_comb begin
        active_source_next = active_source_reg;
        last_status_next   = last_status_reg;
        track_next         = track_reg;
        held_data_next     = held_data_reg;
        held_valid_next    = held_valid_reg;
        current_byte_next  = current_byte_reg;
        waiting_next       = waiting_reg;
        try_send           = 1'b0;
        send_byte          = current_byte_reg;
        res                = '0;

        if (waiting_reg) begin
            try_send = 1'b1;
        end else if (held_valid_reg) begin
            send_byte       = held_data_reg;
            held_valid_next = 1'b0;
            try_send        = 1'b1;
        end else if (have_head) begin
            res.pop_valid  = 1'b1;
            res.pop_source = 2'(active_source_reg);
            if (!head[7] && msg_idle) begin
                // bare data byte: insert the running status first
                held_data_next  = head;
                held_valid_next = 1'b1;
                send_byte       = last_status_reg[active_source_reg];
            end else begin
                if (head[7] && head != TIMING_CLOCK) begin
                    last_status_next[active_source_reg] = head;
                end
                send_byte = head;
            end
            try_send = 1'b1;
        end else if (msg_idle) begin
            if (active_source_reg == SRC_W'(NUM_SOURCES - 1)) begin
                active_source_next = '0;
            end else begin
                active_source_next = active_source_reg + 1'b1;
            end
        end

        if (try_send) begin
            current_byte_next = send_byte;
            if (s_tx_ready) begin
                res.tx_valid = 1'b1;
                res.tx_byte  = send_byte;
                res.activity = (send_byte != TIMING_CLOCK) && (send_byte != ACTIVE_SENSING);
                track_next   = track_sent(track_reg, send_byte);
                waiting_next = 1'b0;
            end else begin
                waiting_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_source_reg <= '0;
            for (int i = 0; i < NUM_SOURCES; i++) begin
                last_status_reg[i] <= 8'h00;
            end
            track_reg        <= '0;
            held_data_reg    <= 8'h00;
            held_valid_reg   <= 1'b0;
            current_byte_reg <= 8'h00;
            waiting_reg      <= 1'b0;
        end else if (accept) begin
            active_source_reg <= active_source_next;
            last_status_reg   <= last_status_next;
            track_reg         <= track_next;
            held_data_reg     <= held_data_next;
            held_valid_reg    <= held_valid_next;
            current_byte_reg  <= current_byte_next;
            waiting_reg       <= waiting_next;
        end
    end

    mom_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_load   (accept),
        .in_data   (res),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_data)
    );

    assign m_tx_valid   = out_data.tx_valid;
    assign m_tx_byte    = out_data.tx_byte;
    assign m_pop_valid  = out_data.pop_valid;
    assign m_pop_source = out_data.pop_source;
    assign m_activity   = out_data.activity;

endmodule

`default_nettype wire
